// ===== design/fwbu_pkg.sv =====
// package for the fixed width bit unpacker
// holds payload structs, controller/datapath command and status types, constants
// no dependencies
package fwbu_pkg;

   localparam int MaxWidthDefault = 32;
   localparam int ByteBits        = 8;
   localparam int HeldBits        = 6;
   localparam int CfgBits         = 6;
   localparam int ValueBits       = 32;
   localparam int GroupBits       = 3;

   localparam logic [CfgBits-1:0] BitWidthReset = 6'd8;

   typedef struct packed {
      logic [ByteBits-1:0] data_byte;
      logic                end_of_data;
   } req_type;

   typedef struct packed {
      logic [ValueBits-1:0] value;
      logic                 last_of_byte;
      logic                 last_of_group;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic emit;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_value;
      logic last_value;
      logic out_free;
   } status_type;

   typedef enum logic [1:0] {
      StIdle = 2'b01,
      StEmit = 2'b10
   } state_type;

endpackage

// ===== design/fwbu_ctrl.sv =====
// controller of the fixed width bit unpacker: one-hot load / emit sequencer
// depends on fwbu_pkg
module fwbu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fwbu_pkg::status_type status,
   output fwbu_pkg::cmd_type   cmd
);
   import fwbu_pkg::*;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == StIdle);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (!status.has_value) begin
               // nothing (more) to decode from this byte
               cmd.finish = 1'b1;
               state_in   = StIdle;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_value) begin
                  cmd.finish = 1'b1;
                  state_in   = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/fwbu_dpath.sv =====
// datapath of the fixed width bit unpacker: bit accumulator, extractor, output register
// depends on fwbu_pkg
module fwbu_dpath #(
   parameter int MAX_WIDTH = fwbu_pkg::MaxWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fwbu_pkg::req_type             req_data,
   input  logic                          csr_valid,
   input  logic [fwbu_pkg::CfgBits-1:0]  csr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fwbu_pkg::rsp_type             rsp_data,
   input  fwbu_pkg::cmd_type             cmd,
   output fwbu_pkg::status_type          status
);
   import fwbu_pkg::*;

   localparam int AccBits  = MAX_WIDTH + ByteBits - 1;
   localparam int LongBits = (AccBits > ValueBits) ? AccBits : ValueBits;

   logic [CfgBits-1:0]   width_ff;
   logic [AccBits-1:0]   acc_ff, acc_in;
   logic [HeldBits-1:0]  held_ff, held_in;
   logic [GroupBits-1:0] cnt_ff, cnt_in;
   logic                 eod_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [HeldBits-1:0]  w;
   logic [HeldBits-1:0]  diff;
   logic [LongBits-1:0]  shifted;
   logic [ValueBits:0]   vone;
   logic [ValueBits-1:0] vmask;
   logic [AccBits:0]     kone;
   logic [AccBits:0]     kmask;
   logic [ValueBits-1:0] value;
   logic                 group_end;

   // zero acts as one, anything above the maximum acts as the maximum
   always_comb begin
      if (width_ff == '0) begin
         w = HeldBits'(1);
      end else if (width_ff > CfgBits'(MAX_WIDTH)) begin
         w = HeldBits'(MAX_WIDTH);
      end else begin
         w = HeldBits'(width_ff);
      end
   end

   assign diff      = held_ff - w;
   assign shifted   = LongBits'(acc_ff) >> diff;
   assign vone      = {{ValueBits{1'b0}}, 1'b1} << w;
   assign vmask     = vone[ValueBits-1:0] - ValueBits'(1);
   assign value     = shifted[ValueBits-1:0] & vmask;
   assign kone      = {{AccBits{1'b0}}, 1'b1} << diff;
   assign kmask     = kone - (AccBits+1)'(1);
   assign group_end = (cnt_ff == {GroupBits{1'b1}});

   assign status.has_value  = (held_ff >= w);
   assign status.last_value = group_end || (diff < w);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      acc_in  = acc_ff;
      held_in = held_ff;
      cnt_in  = cnt_ff;
      if (cmd.load) begin
         acc_in  = {acc_ff[AccBits-ByteBits-1:0], req_data.data_byte};
         held_in = held_ff + HeldBits'(ByteBits);
      end
      if (cmd.emit) begin
         acc_in  = acc_ff & kmask[AccBits-1:0];
         held_in = diff;
         cnt_in  = cnt_ff + GroupBits'(1);
         if (group_end) begin
            // group complete: leftover bits of the byte are dropped
            acc_in  = '0;
            held_in = '0;
            cnt_in  = '0;
         end
      end
      if (cmd.finish && eod_ff) begin
         acc_in  = '0;
         held_in = '0;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= BitWidthReset;
         acc_ff       <= '0;
         held_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            width_ff <= csr_data;
         end
         acc_ff  <= acc_in;
         held_ff <= held_in;
         cnt_ff  <= cnt_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         eod_ff <= req_data.end_of_data;
      end
      if (cmd.emit) begin
         rsp_ff.value         <= value;
         rsp_ff.last_of_byte  <= status.last_value;
         rsp_ff.last_of_group <= group_end;
      end
   end

endmodule

// ===== design/fixed_width_bit_unpacker_top.sv =====
// channel   ports                        payload
// req       req_valid/req_ready          req_data: data_byte, end_of_data
// rsp       rsp_valid/rsp_ready          rsp_data: value, last_of_byte, last_of_group
// csr       csr_valid/csr_ready          csr_data: bit_width
//
// a byte is first loaded into the bit accumulator; the extractor then gives one value per cycle
// out of it while the rsp output has room, until the last value of the byte is emitted
// a byte that yields no value is loaded and then finished without emitting
// a stalled rsp holds the extractor; the next byte is taken while the last value waits
// reset (synchronous) restores bit_width 8 and empties the accumulator and group count
// top level of the fixed width bit unpacker; depends on fwbu_pkg, fwbu_ctrl, fwbu_dpath
module fixed_width_bit_unpacker_top #(
   parameter int MAX_WIDTH = fwbu_pkg::MaxWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  fwbu_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output fwbu_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fwbu_pkg::CfgBits-1:0]  csr_data
);
   import fwbu_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   fwbu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fwbu_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   a_one_byte_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("byte taken while previous byte still decoding");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("value emitted over an untaken result");

   a_group_end_ends_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_of_group) |-> rsp_data.last_of_byte)
      else $error("group end not flagged as last value of byte");

endmodule

// ===== bench/fwbu_value_checker.sv =====
// value checker for the fixed width bit unpacker: follows byte, csr and result transfers,
// predicts the decoded values and compares each result field by field
// depends on fwbu_pkg
module fwbu_value_checker #(
   parameter int MAX_WIDTH = fwbu_pkg::MaxWidthDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  fwbu_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  fwbu_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [fwbu_pkg::CfgBits-1:0] csr_data,
   output int                           failures,
   output int                           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import fwbu_pkg::*;

   localparam int AccBits   = 39;
   localparam int GroupSize = 8;

   logic [CfgBits-1:0]   width_reg = BitWidthReset;
   logic [AccBits-1:0]   held_bits = '0;
   int                   held_count = 0;
   logic [GroupBits-1:0] group_count = '0;
   rsp_type              decoded_q[$];
   int                   mismatches = 0;

   // zero acts as one, anything above the maximum as the maximum
   function automatic int active_width();
      int w;
      w = int'(width_reg);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic void decode_byte(input req_type item);
      logic [63:0] acc;
      int          w;
      int          n;
      bit          group_end;
      rsp_type     batch[GroupSize];
      w   = active_width();
      acc = (({25'd0, held_bits} << ByteBits) | 64'(item.data_byte)) &
            ((64'd1 << AccBits) - 64'd1);
      held_count = held_count + ByteBits;
      n = 0;
      while (held_count >= w && n < GroupSize) begin
         held_count = held_count - w;
         batch[n].value = 32'((acc >> held_count) & ((64'd1 << w) - 64'd1));
         acc = acc & ((64'd1 << held_count) - 64'd1);
         group_count = group_count + GroupBits'(1);
         group_end = (group_count == '0);
         batch[n].last_of_byte  = 1'b0;
         batch[n].last_of_group = group_end;
         n++;
         // eighth value: whatever is left of the byte is dropped
         if (group_end) begin
            acc = '0;
            held_count = 0;
            break;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (i == n - 1) batch[i].last_of_byte = 1'b1;
         decoded_q.push_back(batch[i]);
      end
      held_bits = acc[AccBits-1:0];
      // end of data throws away any partial group after the byte is decoded
      if (item.end_of_data) begin
         held_bits   = '0;
         held_count  = 0;
         group_count = '0;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         width_reg   = BitWidthReset;
         held_bits   = '0;
         held_count  = 0;
         group_count = '0;
         decoded_q.delete();
      end else begin
         if (csr_valid && csr_ready) width_reg = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: result with none expected, got value %h",
                        $time, rsp_data.value);
               $display("%0t: got last_of_byte %b last_of_group %b",
                        $time, rsp_data.last_of_byte, rsp_data.last_of_group);
               mismatches++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, got %h",
                           $time, want.value, rsp_data.value);
                  mismatches++;
               end
               if (rsp_data.last_of_byte !== want.last_of_byte) begin
                  $display("%0t: last_of_byte mismatch, expected %b, got %b",
                           $time, want.last_of_byte, rsp_data.last_of_byte);
                  mismatches++;
               end
               if (rsp_data.last_of_group !== want.last_of_group) begin
                  $display("%0t: last_of_group mismatch, expected %b, got %b",
                           $time, want.last_of_group, rsp_data.last_of_group);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) decode_byte(req_data);
      end
      failures <= mismatches;
      pending  <= decoded_q.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the fixed width bit unpacker: clock, reset, byte and csr stimulus,
// random result back-pressure and the verdict
// depends on fwbu_pkg, fixed_width_bit_unpacker_top and fwbu_value_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fwbu_pkg::*;

   localparam int RandomItems  = 170;
   localparam int SettleCycles = 12;
   localparam int LongHold     = 300;
   localparam int CycleLimit   = 500000;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [CfgBits-1:0] csr_data;
   int                 failures;
   int                 pending;
   logic               stall_now = 1'b0;
   int                 cycles = 0;

   fixed_width_bit_unpacker_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   fwbu_value_checker #(
      .MAX_WIDTH (MaxWidthDefault)
   ) value_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // mostly no gap, some short ones, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CfgBits-1:0] pick_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return CfgBits'($urandom_range(1, 8));
      if (r < 85) return CfgBits'($urandom_range(9, 16));
      if (r < 95) return CfgBits'($urandom_range(17, 32));
      if ($urandom_range(0, 1) == 0) return '0;
      return CfgBits'($urandom_range(33, 63));
   endfunction

   task automatic send_byte(input logic [ByteBits-1:0] b, input logic eod);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, end_of_data: eod};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_width(input logic [CfgBits-1:0] w);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every expected value, then give a byte with no value time to finish
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // result side: runs of ready, random stalls, and one long hold-off on request
   initial begin
      int n;
      bit on;
      bit hold_done;
      n         = 0;
      on        = 1'b0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_now && !hold_done) begin
            // long hold-off while the sender keeps offering bytes
            rsp_ready <= 1'b0;
            repeat (LongHold - 1) @(negedge clock);
            hold_done = 1'b1;
            n = 0;
         end else begin
            while (n == 0) begin
               on = !on;
               n  = on ? int'($urandom_range(1, 40)) : pick_gap();
            end
            rsp_ready <= on;
            n--;
         end
      end
   end

   initial begin
      logic [CfgBits-1:0] w;
      int                 group_len;
      int                 total;
      int                 phase;
      int                 sent;
      bit                 eod_last;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // width out of reset is 8: one value per byte
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();
      write_width(6'd1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      drain();
      // widest values: three bytes with no value, a fourth that completes one, then end of data discards the rest
      write_width(6'd32);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();
      write_width(6'd0);
      send_byte(8'h5A, 1'b0);
      drain();
      write_width(6'd63);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7E, 1'b0);
      drain();
      write_width(6'd3);
      send_byte(8'hC3, 1'b0);
      drain();
      // narrower mid-group: group closes inside the byte and its tail is dropped
      write_width(6'd1);
      send_byte(8'h81, 1'b0);
      drain();
      write_width(6'd5);
      send_byte(8'hF0, 1'b1);
      drain();

      sent  = 0;
      phase = 0;
      while (sent < RandomItems) begin
         if (phase == 0) begin
            w     = 6'd1;
            total = 8;
         end else begin
            w = pick_width();
            group_len = (w == 0) ? 1 : ((w > MaxWidthDefault) ? MaxWidthDefault : int'(w));
            total = group_len * ((group_len <= 8) ? $urandom_range(1, 3) : 1);
            // cut the buffer short now and then, leaving a partial group
            if ($urandom_range(0, 3) == 0) total = $urandom_range(1, total);
         end
         write_width(w);
         if (phase == 0) stall_now = 1'b1;
         eod_last = 1'($urandom_range(0, 1));
         for (int i = 0; i < total; i++) begin
            send_byte(8'($urandom_range(0, 255)),
                      (i == total - 1 && eod_last) || ($urandom_range(0, 24) == 0));
            sent++;
         end
         drain();
         phase++;
      end

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
